>>> design/crc16_frame_receiver_assert.svh
// assertion macros for the crc16 frame receiver
// no dependencies; included by the top level
`ifndef CRC16_FRAME_RECEIVER_ASSERT_SVH
`define CRC16_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication
`define CRC16FR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CRC16FR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/crc16fr_pkg.sv
// shared constants for the crc16 frame receiver
// no dependencies
package crc16fr_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 6;
  localparam int ID_W   = 16;
  localparam int CRC_W  = 16;
  localparam int OUT_W  = 64;

  localparam logic [CRC_W-1:0]  CRC_POLY      = 16'h1021;
  localparam logic [BYTE_W-1:0] DEF_START     = 8'h30;
  localparam logic [BYTE_W-1:0] DEF_END       = 8'h04;
  localparam logic [LEN_W-1:0]  HDR_LAST_IDX  = 6'd6;

  localparam logic REG_START = 1'b0;
  localparam logic REG_END   = 1'b1;

  localparam logic KIND_HDR     = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

endpackage

>>> design/crc16_frame_receiver.sv
// crc16 frame receiver: start/end framed packet deframer with crc-16 check
// depends on crc16fr_pkg and crc16_frame_receiver_assert.svh

// One received byte per input request. A header or payload byte is accepted
// and then folded in by the single shared CRC shift stage, one bit per cycle;
// start, CRC and end bytes are taken without a shift stage. When the end byte
// closes a good frame the block emits a header result and then one result per
// payload byte, read from the on-chip payload memory, each with one memory read
// and one output load; output back-pressure stretches this. No input is taken
// while a byte is being folded in or results are being emitted; the last result
// may still sit in the output register while the next byte is taken. No clearing
// pass after reset.
module crc16_frame_receiver #(
  parameter int MAX_DATA = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] first_command, [15:8] second_command, [31:16] source_id,
  // [47:32] destination_id, [53:48] payload_length, [61:54] payload_byte, [63:62] zero
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast,   // last_of_frame
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
  localparam logic [crc16fr_pkg::BYTE_W-1:0] MAX_LEN = crc16fr_pkg::BYTE_W'(MAX_DATA);

  typedef enum logic [2:0] {
    PH_HUNT, PH_HEADER, PH_PAYLOAD, PH_CRC, PH_END
  } phase_t;

  typedef enum logic [2:0] {
    C_IDLE, C_SHIFT, C_HDR, C_FETCH, C_LOAD
  } ctl_t;

  phase_t phase;
  ctl_t   ctl;

  logic [crc16fr_pkg::BYTE_W-1:0] start_byte;
  logic [crc16fr_pkg::BYTE_W-1:0] end_byte;
  logic [crc16fr_pkg::LEN_W-1:0]  byte_index;
  logic [crc16fr_pkg::BYTE_W-1:0] held_first_command;
  logic [crc16fr_pkg::BYTE_W-1:0] held_second_command;
  logic [crc16fr_pkg::ID_W-1:0]   held_source;
  logic [crc16fr_pkg::ID_W-1:0]   held_destination;
  logic [crc16fr_pkg::LEN_W-1:0]  held_length;
  logic [crc16fr_pkg::CRC_W-1:0]  running_crc;
  logic [crc16fr_pkg::CRC_W-1:0]  received_crc;
  logic [2:0]                     bit_cnt;
  logic [crc16fr_pkg::LEN_W-1:0]  emit_idx;

  logic                            out_valid;
  logic                            out_kind;
  logic                            out_last;
  logic [crc16fr_pkg::OUT_W-1:0]   out_data;

  logic [crc16fr_pkg::BYTE_W-1:0] payload_store [MAX_DATA];
  logic [crc16fr_pkg::BYTE_W-1:0] mem_q;

  logic                           in_accept;
  logic                           slot_free;
  logic                           out_load;
  logic                           mem_we;
  logic                           emit_last;
  logic [crc16fr_pkg::BYTE_W-1:0] b;
  logic [crc16fr_pkg::CRC_W-1:0]  crc_shift;
  logic [crc16fr_pkg::CRC_W-1:0]  crc_step;
  logic [crc16fr_pkg::LEN_W-1:0]  index_inc;
  logic [crc16fr_pkg::LEN_W-1:0]  emit_inc;

  assign s_axis_tready = (ctl == C_IDLE);
  assign cfg_ready     = 1'b1;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign slot_free     = !out_valid || m_axis_tready;
  assign out_load      = slot_free && (ctl == C_HDR || ctl == C_LOAD);
  assign mem_we        = in_accept && (phase == PH_PAYLOAD);
  assign crc_shift     = {running_crc[crc16fr_pkg::CRC_W-2:0], 1'b0};
  assign crc_step      = running_crc[crc16fr_pkg::CRC_W-1] ?
                         (crc_shift ^ crc16fr_pkg::CRC_POLY) : crc_shift;
  assign index_inc     = byte_index + 6'd1;
  assign emit_inc      = emit_idx + 6'd1;
  assign emit_last     = (emit_inc == held_length);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

  // payload memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      payload_store[byte_index[AW-1:0]] <= b;
    end
    if (ctl == C_FETCH) begin
      mem_q <= payload_store[emit_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl                 <= C_IDLE;
      phase               <= PH_HUNT;
      start_byte          <= crc16fr_pkg::DEF_START;
      end_byte            <= crc16fr_pkg::DEF_END;
      byte_index          <= '0;
      held_first_command  <= '0;
      held_second_command <= '0;
      held_source         <= '0;
      held_destination    <= '0;
      held_length         <= '0;
      running_crc         <= '0;
      received_crc        <= '0;
      bit_cnt             <= '0;
      emit_idx            <= '0;
      out_valid           <= 1'b0;
      out_kind            <= crc16fr_pkg::KIND_HDR;
      out_last            <= 1'b0;
      out_data            <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          crc16fr_pkg::REG_START: start_byte <= cfg_data;
          crc16fr_pkg::REG_END:   end_byte   <= cfg_data;
        endcase
      end

      if (out_valid && m_axis_tready && !out_load) begin
        out_valid <= 1'b0;
      end

      unique case (ctl)
        C_IDLE: begin
          if (in_accept) begin
            case (phase)
              PH_HEADER: begin
                running_crc <= running_crc ^ {b, 8'h00};
                bit_cnt     <= '0;
                ctl         <= C_SHIFT;
                unique case (byte_index[2:0])
                  3'd0: held_first_command <= b;
                  3'd1: held_second_command <= b;
                  3'd2: held_source[15:8] <= b;
                  3'd3: held_source[7:0] <= b;
                  3'd4: held_destination[15:8] <= b;
                  3'd5: held_destination[7:0] <= b;
                  default: ;
                endcase
                if (byte_index >= crc16fr_pkg::HDR_LAST_IDX) begin
                  byte_index <= '0;
                  if (b > MAX_LEN) begin
                    phase <= PH_HUNT;
                  end else begin
                    held_length <= b[crc16fr_pkg::LEN_W-1:0];
                    phase <= (b[crc16fr_pkg::LEN_W-1:0] == '0) ? PH_CRC : PH_PAYLOAD;
                  end
                end else begin
                  byte_index <= index_inc;
                end
              end
              PH_PAYLOAD: begin
                running_crc <= running_crc ^ {b, 8'h00};
                bit_cnt     <= '0;
                ctl         <= C_SHIFT;
                if (index_inc >= held_length) begin
                  byte_index <= '0;
                  phase      <= PH_CRC;
                end else begin
                  byte_index <= index_inc;
                end
              end
              PH_CRC: begin
                received_crc <= {received_crc[7:0], b};
                if (byte_index != '0) begin
                  byte_index <= '0;
                  phase      <= PH_END;
                end else begin
                  byte_index <= 6'd1;
                end
              end
              PH_END: begin
                phase      <= PH_HUNT;
                byte_index <= '0;
                if (b == end_byte && received_crc == running_crc) begin
                  ctl <= C_HDR;
                end
              end
              default: begin
                phase <= PH_HUNT;
                if (b == start_byte) begin
                  phase        <= PH_HEADER;
                  byte_index   <= '0;
                  running_crc  <= '0;
                  received_crc <= '0;
                end
              end
            endcase
          end
        end
        C_SHIFT: begin
          running_crc <= crc_step;
          bit_cnt     <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            ctl <= C_IDLE;
          end
        end
        C_HDR: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_kind  <= crc16fr_pkg::KIND_HDR;
            out_last  <= (held_length == '0);
            out_data  <= {2'b00, 8'h00, held_length, held_destination, held_source,
                          held_second_command, held_first_command};
            emit_idx  <= '0;
            ctl       <= (held_length == '0) ? C_IDLE : C_FETCH;
          end
        end
        C_FETCH: begin
          ctl <= C_LOAD;
        end
        C_LOAD: begin
          if (slot_free) begin
            out_valid <= 1'b1;
            out_kind  <= crc16fr_pkg::KIND_PAYLOAD;
            out_last  <= emit_last;
            out_data  <= {2'b00, mem_q, held_length, held_destination, held_source,
                          held_second_command, held_first_command};
            emit_idx  <= emit_inc;
            ctl       <= emit_last ? C_IDLE : C_FETCH;
          end
        end
        default: begin
          ctl <= C_IDLE;
        end
      endcase
    end
  end

`include "crc16_frame_receiver_assert.svh"

  `CRC16FR_ASSERT_NEXT(a_shift_blocks_input, clk, rst,
    in_accept && (phase == PH_HEADER || phase == PH_PAYLOAD), !s_axis_tready,
    "input taken while crc bits still pending")

  `CRC16FR_ASSERT_NEXT(a_shift_length, clk, rst,
    ctl == C_SHIFT && bit_cnt == 3'd7, ctl == C_IDLE,
    "crc shift did not end after eight steps")

  `CRC16FR_ASSERT_NOW(a_emit_while_hunting, clk, rst,
    ctl == C_HDR || ctl == C_FETCH || ctl == C_LOAD, phase == PH_HUNT,
    "results emitted outside hunting phase")

  `CRC16FR_ASSERT_NOW(a_header_no_payload, clk, rst,
    m_axis_tvalid && m_axis_tuser == crc16fr_pkg::KIND_HDR, m_axis_tdata[61:54] == 8'h00,
    "header result carries a payload byte")

endmodule
